FILE: rtl/agce_pkg.sv
// Shared types and constants for the affine GF(2) cycle enumerator.
package agce_pkg;

	localparam int COL_BITS = 8;
	localparam int NUM_COLS = 8;

	typedef enum logic [1:0] {
		REG_NUM_BITS = 2'd0,
		REG_MATRIX   = 2'd1,
		REG_OFFSET   = 2'd2,
		REG_SPARE    = 2'd3
	} agce_reg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_SCHK,
		ST_MARK,
		ST_NRD,
		ST_EMIT
	} agce_state_t;

	typedef struct packed {
		logic [3:0]                     n;
		logic [NUM_COLS*COL_BITS-1:0]   cols;
		logic [COL_BITS-1:0]            offset;
	} agce_map_cfg_t;

endpackage

FILE: rtl/agce_map_unit.sv
// Registered affine map unit: y = M*x XOR c over GF(2) on the low byte.
module agce_map_unit
	import agce_pkg::*;
(
	input  logic                clk,
	input  agce_map_cfg_t       cfg,
	input  logic [COL_BITS-1:0] x,
	output logic [COL_BITS-1:0] y_q
);

	logic [COL_BITS-1:0] acc;

	always_comb begin
		acc = cfg.offset;
		for (int m = 0; m < NUM_COLS; m++) begin
			if (x[m] && (int'(cfg.n) > m)) begin
				acc = acc ^ cfg.cols[COL_BITS*m +: COL_BITS];
			end
		end
	end

	always_ff @(posedge clk) begin
		y_q <= acc;
	end

endmodule

FILE: rtl/affine_gf2_cycle_enumerator.sv
// Top level of the affine GF(2) cycle enumerator with its seen-map memory and sequencer.
//
//  Channel | Signals                              | Direction | Contents
//  --------+--------------------------------------+-----------+-------------------------------
//  request | s_tvalid s_tready s_tdata            | in        | restart
//  result  | m_tvalid m_tready m_tdata m_tlast    | out       | element, closes_cycle,
//          | m_tuser                              |           | opens_cycle, done_res
//  config  | cfg_valid cfg_ready cfg_index        | in        | num_bits, matrix_columns,
//          | cfg_data                             |           | offset_vector
//
// A request on an open path goes from the accepting state through ST_MARK, ST_NRD and
// ST_EMIT before the result register loads. Opening a path first runs ST_SCAN and ST_SCHK
// for each seen-map entry the scan passes, as each probe waits on the registered seen-map
// read; done goes from ST_SCAN to ST_EMIT. A restart first clears the seen map, then
// proceeds as above. After reset the same clearing pass runs with s_tready low.
// s_tready is high only when no request is in progress; a result waiting on m_tready
// does not hold up work on the next request until that result is ready to be loaded.
module affine_gf2_cycle_enumerator
	import agce_pkg::*;
#(
	parameter int MAX_BITS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [7:0]              s_tdata,   // [0] restart
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [7:0]              m_tdata,   // [7:0] element
	output logic                    m_tlast,   // closes_cycle
	output logic [1:0]              m_tuser,   // [0] opens_cycle, [1] done_res
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [1:0]              cfg_index,
	input  logic [63:0]             cfg_data
);

	localparam int VW    = MAX_BITS;
	localparam int NW    = $clog2(MAX_BITS + 1);
	localparam int DEPTH = 1 << MAX_BITS;

	agce_state_t state_q, state_d;

	logic [3:0]          cfg_nb_q;
	logic [63:0]         cfg_cols_q;
	logic [7:0]          cfg_off_q;

	logic [VW-1:0]       clr_cnt_q;
	logic                pend_q;
	logic [VW:0]         scan_q;
	logic [VW-1:0]       cur_q;
	logic                inside_q;
	logic [VW-1:0]       elem_q;
	logic                opens_q;
	logic                done_q;
	logic [VW-1:0]       next_q;

	logic                out_valid_q;
	logic [7:0]          out_elem_q;
	logic                out_opens_q;
	logic                out_closes_q;
	logic                out_done_q;

	logic                seen_mem [DEPTH];
	logic                rdata_q;

	logic [NW-1:0]       n_eff;
	logic [VW:0]         size;
	logic [VW-1:0]       mask;
	logic [VW-1:0]       next_v;
	logic                at_end;
	logic                out_free;
	logic                accept;

	logic                mem_we;
	logic                mem_wdata;
	logic [VW-1:0]       mem_waddr;
	logic                mem_re;
	logic [VW-1:0]       mem_raddr;

	agce_map_cfg_t       map_cfg;
	logic [7:0]          map_y;

	always_comb begin
		if (cfg_nb_q == '0) begin
			n_eff = NW'(1);
		end else if (int'(cfg_nb_q) > MAX_BITS) begin
			n_eff = NW'(MAX_BITS);
		end else begin
			n_eff = NW'(cfg_nb_q);
		end
		size = (VW+1)'(1) << n_eff;
		mask = VW'(size - (VW+1)'(1));
	end

	assign map_cfg.n      = (int'(n_eff) > NUM_COLS) ? 4'(NUM_COLS) : 4'(n_eff);
	assign map_cfg.cols   = cfg_cols_q;
	assign map_cfg.offset = cfg_off_q;

	agce_map_unit u_map (
		.clk (clk),
		.cfg (map_cfg),
		.x   (8'(elem_q)),
		.y_q (map_y)
	);

	assign next_v   = VW'(map_y) & mask;
	assign at_end   = (scan_q >= size);
	assign out_free = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == '1) begin
					state_d = pend_q ? ST_SCAN : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					priority if (s_tdata[0]) begin
						state_d = ST_CLEAR;
					end else if (inside_q) begin
						state_d = ST_MARK;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: state_d = at_end ? ST_EMIT : ST_SCHK;
			ST_SCHK: state_d = rdata_q ? ST_SCAN : ST_MARK;
			ST_MARK: state_d = ST_NRD;
			ST_NRD:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		mem_we    = 1'b0;
		mem_wdata = 1'b0;
		mem_waddr = elem_q;
		mem_re    = 1'b0;
		mem_raddr = scan_q[VW-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
			end
			ST_IDLE: s_tready = 1'b1;
			ST_SCAN: mem_re = !at_end;
			ST_MARK: begin
				mem_we    = 1'b1;
				mem_wdata = 1'b1;
			end
			ST_NRD: begin
				mem_re    = 1'b1;
				mem_raddr = next_v;
			end
			ST_SCHK, ST_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			seen_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= seen_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cfg_nb_q    <= 4'd8;
			cfg_cols_q  <= '0;
			cfg_off_q   <= '0;
			clr_cnt_q   <= '0;
			pend_q      <= 1'b0;
			scan_q      <= '0;
			cur_q       <= '0;
			inside_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				unique case (agce_reg_t'(cfg_index))
					REG_NUM_BITS: cfg_nb_q   <= cfg_data[3:0];
					REG_MATRIX:   cfg_cols_q <= cfg_data;
					REG_OFFSET:   cfg_off_q  <= cfg_data[7:0];
					REG_SPARE: begin
					end
					default: begin
					end
				endcase
			end
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + VW'(1);
				if (clr_cnt_q == '1) begin
					scan_q   <= '0;
					cur_q    <= '0;
					inside_q <= 1'b0;
					pend_q   <= 1'b0;
				end
			end
			if (accept && s_tdata[0]) begin
				pend_q    <= 1'b1;
				clr_cnt_q <= '0;
			end
			if (state_q == ST_SCHK && rdata_q) begin
				scan_q <= scan_q + (VW+1)'(1);
			end
			if (state_q == ST_EMIT && out_free && !done_q) begin
				inside_q <= !rdata_q;
				cur_q    <= next_q;
			end
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !s_tdata[0] && inside_q) begin
			elem_q  <= cur_q & mask;
			opens_q <= 1'b0;
			done_q  <= 1'b0;
		end
		if (state_q == ST_SCAN && at_end) begin
			done_q <= 1'b1;
		end
		if (state_q == ST_SCHK && !rdata_q) begin
			elem_q  <= scan_q[VW-1:0];
			opens_q <= 1'b1;
			done_q  <= 1'b0;
		end
		if (state_q == ST_NRD) begin
			next_q <= next_v;
		end
		if (state_q == ST_EMIT && out_free) begin
			if (done_q) begin
				out_elem_q   <= '0;
				out_opens_q  <= 1'b0;
				out_closes_q <= 1'b0;
				out_done_q   <= 1'b1;
			end else begin
				out_elem_q   <= 8'(elem_q);
				out_opens_q  <= opens_q;
				out_closes_q <= rdata_q;
				out_done_q   <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_elem_q;
	assign m_tlast  = out_closes_q;
	assign m_tuser  = {out_done_q, out_opens_q};

	// The seen map is never marked while a new transaction can be taken.
	assert property (@(posedge clk) disable iff (!arst_n) s_tready |-> !mem_we)
		else $error("seen map written while idle");

	// A done result carries no element and no path flags.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (m_tdata == 8'd0 && !m_tlast && !m_tuser[0]))
		else $error("done result carries element data");

	// An element is marked straight after acceptance on an open path (checked here) or a found gap.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && accept && !s_tdata[0] && inside_q) |=> (state_q == ST_MARK))
		else $error("open path did not proceed to marking");

endmodule
